[design/utf16_string_extractor_macros.svh]
// Assertion macros shared by the string extractor RTL.
`ifndef UTF16_STRING_EXTRACTOR_MACROS_SVH
`define UTF16_STRING_EXTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define U16SE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define U16SE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define U16SE_ASSERT(lbl, clk, rst_n, prop, msg)
`define U16SE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/u16se_pkg.sv]
// Types, constants and UTF-16 to UTF-8 helper functions of the string extractor.
package u16se_pkg;

    localparam int ML_W    = 5;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;

    typedef logic [15:0] t_unit;

    // Register select, taken from paddr[3] (registers lie at 8-byte steps).
    localparam logic REG_MIN_LENGTH   = 1'b0;
    localparam logic REG_BASE_ADDRESS = 1'b1;

    // Result kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam t_unit SURR_LO     = 16'hD800;
    localparam t_unit SURR_HI     = 16'hDFFF;
    localparam t_unit CTRL_MAX    = 16'h001F;
    localparam t_unit UTF8_1B_TOP = 16'h007F;
    localparam t_unit UTF8_2B_TOP = 16'h07FF;

    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] CONT      = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;

    // A unit is allowed unless it is NUL, a control code or a surrogate.
    function automatic logic unit_allowed(input t_unit u);
        return (u > CTRL_MAX) && !((u >= SURR_LO) && (u <= SURR_HI));
    endfunction

    // Number of UTF-8 bytes for a code unit: 1, 2 or 3.
    function automatic logic [1:0] utf8_len(input t_unit cp);
        logic [1:0] len;
        if (cp <= UTF8_1B_TOP) begin
            len = 2'd1;
        end else if (cp <= UTF8_2B_TOP) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    // UTF-8 byte number idx of a code unit.
    function automatic logic [7:0] utf8_byte(input t_unit cp, input logic [1:0] idx);
        logic [7:0] b;
        case (utf8_len(cp))
            2'd1: begin
                b = cp[7:0];
            end
            2'd2: begin
                if (idx == 2'd0) begin
                    b = LEAD2 | {3'b000, cp[10:6]};
                end else begin
                    b = CONT | (cp[7:0] & CONT_MASK);
                end
            end
            default: begin
                case (idx)
                    2'd0: begin
                        b = LEAD3 | {4'b0000, cp[15:12]};
                    end
                    2'd1: begin
                        b = CONT | (cp[13:6] & CONT_MASK);
                    end
                    default: begin
                        b = CONT | (cp[7:0] & CONT_MASK);
                    end
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[design/utf16_string_extractor.sv]
// UTF-16LE string scanner that reports runs of allowed units as a UTF-8 byte stream.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+------------------------------------------
//  input    | in        | i_valid / o_stall       | i_code_unit, i_end_of_buffer
//  output   | out       | o_valid / i_stall       | o_kind, o_text_byte, o_string_address,
//           |           |                         | o_unit_offset, o_last
//  config   | in/out    | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// An item with no result, or whose unit is only held, is taken in ST_IDLE; one that only
// closes a string goes on to ST_END. One that emits its unit goes to ST_CUR, one result
// per UTF-8 byte, then to ST_END when it also closes the string. A flush first reads each
// held unit in ST_READ and pushes its bytes in ST_HELD, one result per cycle while not stalled.
// Reset is synchronous and needs no clearing pass; the hold memory is not cleared.
// An output stall freezes the sequencer, but the next item is taken while the last waits.

`include "utf16_string_extractor_macros.svh"

module utf16_string_extractor #(
    parameter int MAX_MIN_LENGTH = 16,
    parameter int POSITION_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [15:0]                    i_code_unit,
    input  logic                           i_end_of_buffer,
    // Output channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_kind,
    output logic [7:0]                     o_text_byte,
    output logic [63:0]                    o_string_address,
    output logic [31:0]                    o_unit_offset,
    output logic                           o_last,
    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [u16se_pkg::PADDR_W-1:0]  paddr,
    input  logic [u16se_pkg::PDATA_W-1:0]  pwdata,
    output logic [u16se_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    // The hold memory keeps the units of a run that has not yet reached its
    // minimum length. At most MAX_MIN_LENGTH-1 units are ever held.
    localparam int HOLD_DEPTH = (MAX_MIN_LENGTH > 1) ? (MAX_MIN_LENGTH - 1) : 1;
    localparam int AW         = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW         = $clog2(MAX_MIN_LENGTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for an item
        ST_READ,    // hold memory read in flight
        ST_HELD,    // emitting the bytes of a held unit
        ST_CUR,     // emitting the bytes of the current unit
        ST_END      // emitting the string-end result
    } t_state;

    t_state                       r_state;

    // Configuration registers.
    logic [u16se_pkg::ML_W-1:0]   r_min_length;
    logic [63:0]                  r_base_address;

    // Scanner state.
    logic [POSITION_BITS-1:0]     r_byte_pos;
    logic [POSITION_BITS-1:0]     r_run_start;
    logic [CW-1:0]                r_run_count;
    logic                         r_emitting;

    // Work registers of the item in progress.
    u16se_pkg::t_unit             r_unit;
    logic [31:0]                  r_cur_off;
    logic                         r_end_pend;
    logic [CW-1:0]                r_flush_n;
    logic [CW-1:0]                r_idx;
    logic [1:0]                   r_bi;

    // Hold memory and its registered read port.
    u16se_pkg::t_unit             r_mem [HOLD_DEPTH];
    u16se_pkg::t_unit             r_rd_data;

    // Output register.
    logic                         r_o_valid;
    logic                         r_o_kind;
    logic [7:0]                   r_o_text_byte;
    logic [63:0]                  r_o_string_address;
    logic [31:0]                  r_o_unit_offset;
    logic                         r_o_last;

    // Decode of the arriving item.
    logic                         accept;
    logic                         allowed;
    logic [u16se_pkg::ML_W-1:0]   need;
    logic                         reach;
    logic                         hold;
    logic                         emit_cur;
    logic                         end_now;
    logic                         end_eob;
    logic [POSITION_BITS-1:0]     n_run_start;
    logic [POSITION_BITS-1:0]     pos_diff;
    logic [47:0]                  pos_wide;
    logic [POSITION_BITS-1:0]     pos_inc;

    // Byte sequencer.
    u16se_pkg::t_unit             emit_cp;
    logic [1:0]                   emit_len;
    logic                         emit_final;
    logic [7:0]                   emit_byte;
    logic [31:0]                  held_off;
    logic                         can_push;
    logic                         out_push;
    logic                         cfg_write;

    always_comb begin
        accept  = i_valid && (r_state == ST_IDLE);
        allowed = u16se_pkg::unit_allowed(i_code_unit);

        // Zero acts as one; values above the hold capacity saturate.
        if (r_min_length == '0) begin
            need = u16se_pkg::ML_W'(1);
        end else if (r_min_length > u16se_pkg::ML_W'(MAX_MIN_LENGTH)) begin
            need = u16se_pkg::ML_W'(MAX_MIN_LENGTH);
        end else begin
            need = r_min_length;
        end

        reach    = allowed && !r_emitting
                   && ((6'(r_run_count) + 6'd1) >= 6'(need));
        hold     = allowed && !r_emitting && !reach;
        emit_cur = allowed && (r_emitting || reach);
        end_now  = !allowed && r_emitting;
        // The last item of the buffer closes a string left open by this unit.
        end_eob  = i_end_of_buffer && emit_cur;

        // A new run starts at the current position when nothing is open.
        if (allowed && !r_emitting && (r_run_count == '0)) begin
            n_run_start = r_byte_pos;
        end else begin
            n_run_start = r_run_start;
        end
        pos_diff = r_byte_pos - n_run_start;
        pos_wide = 48'(pos_diff);
        pos_inc  = r_byte_pos + POSITION_BITS'(2);

        emit_cp    = (r_state == ST_HELD) ? r_rd_data : r_unit;
        emit_len   = u16se_pkg::utf8_len(emit_cp);
        emit_final = (r_bi == (emit_len - 2'd1));
        emit_byte  = u16se_pkg::utf8_byte(emit_cp, r_bi);
        held_off   = 32'(r_idx) << 1;

        can_push  = !r_o_valid || !i_stall;
        out_push  = can_push && ((r_state == ST_HELD) || (r_state == ST_CUR)
                                 || (r_state == ST_END));
        cfg_write = psel && penable && pwrite;
    end

    // Configuration read back.
    always_comb begin
        case (paddr[3])
            u16se_pkg::REG_MIN_LENGTH:   prdata = u16se_pkg::PDATA_W'(r_min_length);
            u16se_pkg::REG_BASE_ADDRESS: prdata = r_base_address;
            default:                     prdata = '0;
        endcase
    end

    // Hold memory: written when a unit is held, read one entry per flush step.
    always_ff @(posedge i_clk) begin
        if (accept && hold) begin
            r_mem[r_run_count[AW-1:0]] <= i_code_unit;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_min_length   <= u16se_pkg::ML_W'(1);
            r_base_address <= '0;
            r_byte_pos     <= '0;
            r_run_start    <= '0;
            r_run_count    <= '0;
            r_emitting     <= 1'b0;
            r_end_pend     <= 1'b0;
            r_idx          <= '0;
            r_bi           <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (paddr[3])
                    u16se_pkg::REG_MIN_LENGTH:   r_min_length <= pwdata[u16se_pkg::ML_W-1:0];
                    u16se_pkg::REG_BASE_ADDRESS: r_base_address <= pwdata;
                    default: ;
                endcase
            end

            // A stalled result stays in the output register; a new push refills it.
            r_o_valid <= out_push || (r_o_valid && i_stall);

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_unit      <= i_code_unit;
                        r_cur_off   <= pos_wide[31:0];
                        r_end_pend  <= end_eob;
                        r_run_start <= n_run_start;
                        r_byte_pos  <= i_end_of_buffer ? '0 : pos_inc;
                        r_flush_n   <= r_run_count;
                        r_idx       <= '0;
                        r_bi        <= '0;
                        r_run_count <= (hold && !i_end_of_buffer)
                                       ? (r_run_count + CW'(1)) : '0;
                        r_emitting  <= emit_cur && !i_end_of_buffer;
                        if (reach && (r_run_count != '0)) begin
                            r_state <= ST_READ;
                        end else if (emit_cur) begin
                            r_state <= ST_CUR;
                        end else if (end_now) begin
                            r_state <= ST_END;
                        end
                    end
                end
                ST_READ: begin
                    r_state <= ST_HELD;
                end
                ST_HELD: begin
                    if (can_push) begin
                        r_o_kind           <= u16se_pkg::KIND_TEXT;
                        r_o_text_byte      <= emit_byte;
                        r_o_string_address <= r_base_address + 64'(r_run_start);
                        r_o_unit_offset    <= held_off;
                        r_o_last           <= 1'b0;
                        if (emit_final) begin
                            r_bi <= '0;
                            if ((r_idx + CW'(1)) == r_flush_n) begin
                                r_state <= ST_CUR;
                            end else begin
                                r_idx   <= r_idx + CW'(1);
                                r_state <= ST_READ;
                            end
                        end else begin
                            r_bi <= r_bi + 2'd1;
                        end
                    end
                end
                ST_CUR: begin
                    if (can_push) begin
                        r_o_kind           <= u16se_pkg::KIND_TEXT;
                        r_o_text_byte      <= emit_byte;
                        r_o_string_address <= r_base_address + 64'(r_run_start);
                        r_o_unit_offset    <= r_cur_off;
                        r_o_last           <= emit_final && !r_end_pend;
                        if (emit_final) begin
                            r_bi    <= '0;
                            r_state <= r_end_pend ? ST_END : ST_IDLE;
                        end else begin
                            r_bi <= r_bi + 2'd1;
                        end
                    end
                end
                ST_END: begin
                    if (can_push) begin
                        r_o_kind           <= u16se_pkg::KIND_END;
                        r_o_text_byte      <= '0;
                        r_o_string_address <= r_base_address + 64'(r_run_start);
                        r_o_unit_offset    <= '0;
                        r_o_last           <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Items enter only while the sequencer is idle.
    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_text_byte      = r_o_text_byte;
    assign o_string_address = r_o_string_address;
    assign o_unit_offset    = r_o_unit_offset;
    assign o_last           = r_o_last;
    assign pready           = 1'b1;

    `U16SE_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, o_valid && (o_kind == u16se_pkg::KIND_END), o_last, "string-end result not marked last")
    `U16SE_ASSERT_IMP(a_offset_even, i_clk, i_rst_n, o_valid && (o_kind == u16se_pkg::KIND_TEXT), o_unit_offset[0] == 1'b0, "odd unit offset")
    `U16SE_ASSERT_IMP(a_hold_not_emit, i_clk, i_rst_n, r_run_count != '0, !r_emitting, "units held while a string is open")
    `U16SE_ASSERT_IMP(a_more_follows, i_clk, i_rst_n, o_valid && !o_last, r_state != ST_IDLE, "sequencer idle before last result")
    `U16SE_ASSERT_IMP(a_flush_bound, i_clk, i_rst_n, r_state == ST_HELD, r_idx < r_flush_n, "flush index beyond held count")

endmodule
